[hdl/esc_pkg.sv]
// Shared types and constants for the elevator sweep controller.
// Used by esc_ctrl, esc_datapath and elevator_sweep_controller_core.
package esc_pkg;

  localparam int ESC_STACK_DEPTH = 7;
  localparam int FLOOR_W         = 3;
  localparam int PENDING_W       = 3;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR = 3'd6;

  // Item kinds on the func field.
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_REQ    = 2'd1;
  localparam logic [1:0] FN_GROUND = 2'd2;

  // Result event codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_MOVED = 2'd1;
  localparam logic [1:0] EV_DOORS = 2'd2;
  localparam logic [1:0] EV_DROP  = 2'd3;

  typedef enum logic {
    PH_IDLE,
    PH_MOVING
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    logic       park;
    logic       move;
    logic       apply_ground;
    logic       mark_ground;
    logic [1:0] ev_code;
    logic       busy;
  } esc_cmd_t;

  // Status from the datapath, already adjusted for a pending ground return.
  typedef struct packed {
    logic ground;
    logic full;
    logic empty;
    logic at_target;
    logic at_park;
  } esc_status_t;

endpackage

[hdl/esc_ctrl.sv]
// Controller for the elevator sweep controller: car phase state machine,
// request handshake and result valid. Depends on esc_pkg.
module esc_ctrl
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  func,
  input  esc_status_t st,
  output esc_cmd_t    cmd
);

  phase_t phase;
  phase_t phase_next;
  phase_t phase_eff;
  logic   take;
  logic   out_valid_next;
  logic   choose_moving;

  // The result register may be refilled in the cycle it drains.
  assign in_stall       = out_valid & out_stall;
  assign take           = in_valid & ~in_stall;
  assign out_valid_next = take | (out_valid & out_stall);

  // A pending ground return puts the car in motion before the tick is handled.
  assign phase_eff     = st.ground ? PH_MOVING : phase;
  assign choose_moving = ~st.empty | ~st.at_park;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    phase_next = phase;
    if (take && func == FN_TICK) begin
      unique case (phase_eff)
        PH_IDLE: begin
          phase_next = choose_moving ? PH_MOVING : PH_IDLE;
        end
        PH_MOVING: begin
          if (st.at_target) begin
            phase_next = choose_moving ? PH_MOVING : PH_IDLE;
          end else begin
            phase_next = PH_MOVING;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.load    = take;
    cmd.ev_code = EV_NONE;
    cmd.busy    = (phase_next == PH_MOVING);
    if (take) begin
      case (func)
        FN_TICK: begin
          cmd.apply_ground = st.ground;
          unique case (phase_eff)
            PH_IDLE: begin
              cmd.pop  = ~st.empty;
              cmd.park = st.empty & ~st.at_park;
            end
            PH_MOVING: begin
              if (st.at_target) begin
                cmd.ev_code = EV_DOORS;
                cmd.pop     = ~st.empty;
                cmd.park    = st.empty & ~st.at_park;
              end else begin
                cmd.ev_code = EV_MOVED;
                cmd.move    = 1'b1;
              end
            end
            default: cmd.ev_code = EV_NONE;
          endcase
        end
        FN_REQ: begin
          if (st.full) begin
            cmd.ev_code = EV_DROP;
          end else begin
            cmd.push = 1'b1;
          end
        end
        FN_GROUND: begin
          cmd.mark_ground = 1'b1;
        end
        default: cmd.ev_code = EV_NONE;
      endcase
    end
  end

endmodule

[hdl/esc_datapath.sv]
// Datapath for the elevator sweep controller: car position and direction,
// target, stop stack memory and the result register. Depends on esc_pkg.
module esc_datapath
  import esc_pkg::*;
#(
  parameter int STACK_DEPTH = ESC_STACK_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic [FLOOR_W-1:0]   floor,
  input  esc_cmd_t             cmd,
  output esc_status_t          st,
  output logic [1:0]           event_res,
  output logic [FLOOR_W-1:0]   car_floor,
  output logic                 heading_up,
  output logic                 busy_res,
  output logic [PENDING_W-1:0] pending
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [FLOOR_W-1:0] cur;
  logic [FLOOR_W-1:0] cur_next;
  logic               going_up;
  logic               going_up_next;
  logic [FLOOR_W-1:0] target;
  logic [FLOOR_W-1:0] target_next;
  logic               park_at_top;
  logic               park_at_top_next;
  logic               ground_forced;
  logic               ground_forced_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      top_index;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [FLOOR_W-1:0] top_data;
  logic [FLOOR_W-1:0] push_floor;
  logic               park_eff;
  logic               dir_eff;
  logic               dir_move;
  logic [FLOOR_W-1:0] park_floor;

  logic [FLOOR_W-1:0] stack_mem [STACK_DEPTH];

  assign park_eff   = ground_forced ? 1'b0 : park_at_top;
  assign dir_eff    = ground_forced ? 1'b0 : going_up;
  assign park_floor = park_eff ? TOP_FLOOR : '0;
  assign push_floor = (floor > TOP_FLOOR) ? TOP_FLOOR : floor;

  assign st.ground    = ground_forced;
  assign st.full      = (count == CW'(STACK_DEPTH));
  assign st.empty     = (count == '0);
  assign st.at_target = ground_forced ? (cur == '0) : (cur == target);
  assign st.at_park   = (cur == park_floor);

  // Turn around at either end of the shaft before taking the step.
  always_comb begin
    dir_move = dir_eff;
    if (dir_eff && cur >= TOP_FLOOR) begin
      dir_move = 1'b0;
    end else if (!dir_eff && cur == '0) begin
      dir_move = 1'b1;
    end
  end

  always_comb begin
    cur_next           = cur;
    going_up_next      = going_up;
    target_next        = target;
    park_at_top_next   = park_at_top;
    ground_forced_next = ground_forced;
    count_next         = count;
    if (cfg_wr_en) begin
      park_at_top_next = cfg_wr_data;
    end
    if (cmd.apply_ground) begin
      ground_forced_next = 1'b0;
      park_at_top_next   = 1'b0;
      going_up_next      = 1'b0;
      target_next        = '0;
    end
    if (cmd.mark_ground) begin
      ground_forced_next = 1'b1;
    end
    if (cmd.pop) begin
      target_next = top_data;
      count_next  = count - 1'b1;
    end
    if (cmd.park) begin
      going_up_next = park_eff;
      target_next   = park_floor;
    end
    if (cmd.move) begin
      going_up_next = dir_move;
      cur_next      = dir_move ? cur + 1'b1 : cur - 1'b1;
    end
    if (cmd.push) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      going_up      <= 1'b1;
      target        <= '0;
      park_at_top   <= 1'b0;
      ground_forced <= 1'b0;
      count         <= '0;
    end else begin
      cur           <= cur_next;
      going_up      <= going_up_next;
      target        <= target_next;
      park_at_top   <= park_at_top_next;
      ground_forced <= ground_forced_next;
      count         <= count_next;
    end
  end

  // The read port always fetches the entry that will be on top after this
  // cycle, so a pop finds its floor already registered.
  assign top_index = count_next - 1'b1;
  assign rd_addr   = top_index[AW-1:0];
  assign wr_addr   = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[wr_addr] <= push_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_data <= push_floor;
    end else begin
      top_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      event_res  <= cmd.ev_code;
      car_floor  <= cur_next;
      heading_up <= going_up_next;
      busy_res   <= cmd.busy;
      pending    <= PENDING_W'(count_next);
    end
  end

endmodule

[hdl/elevator_sweep_controller_core.sv]
// Top level of the elevator sweep controller: joins the phase controller
// and the datapath. Depends on esc_pkg, esc_ctrl and esc_datapath.
//
//   Channel   Handshake              Signals
//   request   in_valid / in_stall    func, floor
//   result    out_valid / out_stall  event_res, car_floor, heading_up, busy_res, pending
//   config    cfg_wr_en              cfg_wr_data (park_at_top)
//
// Each request is handled in the cycle it is accepted; its result appears
// in the output register on the next cycle, one request per cycle sustained while out_stall is low.
// The stack read port prefetches the top entry so a pop finds its floor already registered.
// Requests are stalled only while a result waits in the output register
// under out_stall. Reset is synchronous; no clearing pass is needed.
module elevator_sweep_controller_core
  import esc_pkg::*;
#(
  parameter int STACK_DEPTH = ESC_STACK_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [FLOOR_W-1:0]   floor,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           event_res,
  output logic [FLOOR_W-1:0]   car_floor,
  output logic                 heading_up,
  output logic                 busy_res,
  output logic [PENDING_W-1:0] pending
);

  esc_cmd_t    cmd;
  esc_status_t st;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .func      (func),
    .st        (st),
    .cmd       (cmd)
  );

  esc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .floor       (floor),
    .cmd         (cmd),
    .st          (st),
    .event_res   (event_res),
    .car_floor   (car_floor),
    .heading_up  (heading_up),
    .busy_res    (busy_res),
    .pending     (pending)
  );

endmodule

[sim/elevator_sweep_controller_core_tb.sv]
// Self-checking testbench for elevator_sweep_controller_core: a clocked driver and monitor
// check every result against an in-bench model of the car, its stop stack and parking.
// Depends on esc_pkg and the elevator_sweep_controller_core RTL.
module elevator_sweep_controller_core_tb;
  import esc_pkg::*;

  localparam logic [1:0] FN_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PRINT_CAP   = 40;

  typedef struct packed {
    logic [1:0]         fn;
    logic [FLOOR_W-1:0] fl;
  } car_request_t;

  typedef struct packed {
    logic [1:0]           ev;
    logic [FLOOR_W-1:0]   pos;
    logic                 up;
    logic                 busy;
    logic [PENDING_W-1:0] waiting;
  } car_report_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic                 cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           func;
  logic [FLOOR_W-1:0]   floor;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           event_res;
  logic [FLOOR_W-1:0]   car_floor;
  logic                 heading_up;
  logic                 busy_res;
  logic [PENDING_W-1:0] pending;

  elevator_sweep_controller_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .floor      (floor),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .car_floor  (car_floor),
    .heading_up (heading_up),
    .busy_res   (busy_res),
    .pending    (pending)
  );

  // Car model, starting in its reset state.
  logic               park_high  = 1'b0;
  logic [FLOOR_W-1:0] car_pos    = '0;
  logic               car_dir_up = 1'b1;
  logic [FLOOR_W-1:0] car_goal   = '0;
  phase_t             car_phase  = PH_IDLE;
  logic [FLOOR_W-1:0] stops [ESC_STACK_DEPTH];
  int                 stop_n     = 0;
  logic               ground_req = 1'b0;

  car_request_t request_q[$];
  car_report_t  car_report_q[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int drop_count     = 0;
  int door_count     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take the newest stop, or head for the parking floor when none is left.
  function automatic void pick_goal();
    logic [FLOOR_W-1:0] park_floor;
    if (stop_n > 0) begin
      stop_n    = stop_n - 1;
      car_goal  = stops[stop_n];
      car_phase = PH_MOVING;
    end else begin
      park_floor = park_high ? TOP_FLOOR : '0;
      if (car_pos != park_floor) begin
        car_dir_up = park_high;
        car_goal   = park_floor;
        car_phase  = PH_MOVING;
      end else begin
        car_phase = PH_IDLE;
      end
    end
  endfunction

  function automatic logic [1:0] tick_car();
    if (ground_req) begin
      ground_req = 1'b0;
      park_high  = 1'b0;
      car_dir_up = 1'b0;
      car_goal   = '0;
      car_phase  = PH_MOVING;
    end
    if (car_phase != PH_MOVING) begin
      pick_goal();
      return EV_NONE;
    end
    if (car_pos == car_goal) begin
      pick_goal();
      return EV_DOORS;
    end
    // The car sweeps in its current direction and only turns at the ends.
    if (car_dir_up && car_pos >= TOP_FLOOR) car_dir_up = 1'b0;
    else if (!car_dir_up && car_pos == '0) car_dir_up = 1'b1;
    if (car_dir_up) car_pos = car_pos + 1'b1;
    else car_pos = car_pos - 1'b1;
    return EV_MOVED;
  endfunction

  function automatic car_report_t step_car(input logic [1:0] fn, input logic [FLOOR_W-1:0] fl);
    car_report_t rep;
    rep.ev = EV_NONE;
    case (fn)
      FN_TICK: rep.ev = tick_car();
      FN_REQ: begin
        if (stop_n >= ESC_STACK_DEPTH) begin
          rep.ev = EV_DROP;
        end else begin
          stops[stop_n] = (fl > TOP_FLOOR) ? TOP_FLOOR : fl;
          stop_n        = stop_n + 1;
        end
      end
      FN_GROUND: ground_req = 1'b1;
      default: ;
    endcase
    rep.pos     = car_pos;
    rep.up      = car_dir_up;
    rep.busy    = (car_phase == PH_MOVING);
    rep.waiting = stop_n[PENDING_W-1:0];
    return rep;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("result %0d: %s is %0d, expected %0d", checked_count, field, got, want);
  endtask

  task automatic add_request(input logic [1:0] fn, input logic [FLOOR_W-1:0] fl);
    car_request_t r;
    r.fn = fn;
    r.fl = fl;
    request_q.push_back(r);
  endtask

  // Random traffic: bursts of stop requests with random floors between runs of ticks,
  // some ground returns, and a little unused-code noise that does not count.
  task automatic add_traffic(input int n_items);
    int made;
    int r;
    int len;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 25) begin
        len = (r < 5) ? 8 : $urandom_range(1, 4);
        repeat (len) add_request(FN_REQ, FLOOR_W'($urandom_range(0, 7)));
        made += len;
      end else if (r < 85) begin
        len = $urandom_range(1, 24);
        repeat (len) add_request(FN_TICK, FLOOR_W'($urandom_range(0, 7)));
        made += len;
      end else if (r < 93) begin
        add_request(FN_GROUND, FLOOR_W'($urandom_range(0, 7)));
        made++;
      end else begin
        add_request(FN_UNUSED, FLOOR_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Polled on the falling edge so the clocked processes have settled.
  task automatic wait_drained();
    while (request_q.size() > 0 || in_valid || car_report_q.size() > 0) @(negedge clk);
  endtask

  task automatic set_parking(input logic top);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= top;
    park_high    = top;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    car_request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        car_report_q.push_back(step_car(func, floor));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid <= 1'b1;
          func     <= nxt.fn;
          floor    <= nxt.fl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    car_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (car_report_q.size() == 0) begin
          report_mismatch("unrequested result, event", event_res, -1);
        end else begin
          want = car_report_q.pop_front();
          if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
          if (car_floor !== want.pos) report_mismatch("car_floor", car_floor, want.pos);
          if (heading_up !== want.up) report_mismatch("heading_up", heading_up, want.up);
          if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
          if (pending !== want.waiting) report_mismatch("pending", pending, want.waiting);
          if (want.ev == EV_DROP) drop_count++;
          if (want.ev == EV_DOORS) door_count++;
        end
        checked_count++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_count, car_report_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int pass_i;
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    func        = FN_TICK;
    floor       = '0;
    out_stall   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle tick, unused code, ground return while parked at the ground floor,
    // a full stack with a saturated floor and a dropped request, a sweep that turns at
    // the top, then a ground return while the car is moving.
    add_request(FN_TICK, '0);
    add_request(FN_UNUSED, 3'd7);
    add_request(FN_GROUND, 3'd5);
    add_request(FN_TICK, 3'd7);
    add_request(FN_REQ, 3'd7);
    add_request(FN_REQ, 3'd0);
    add_request(FN_REQ, 3'd6);
    add_request(FN_REQ, 3'd3);
    add_request(FN_REQ, 3'd1);
    add_request(FN_REQ, 3'd5);
    add_request(FN_REQ, 3'd2);
    add_request(FN_REQ, 3'd4);
    repeat (10) add_request(FN_TICK, '0);
    add_request(FN_GROUND, '0);
    repeat (3) add_request(FN_TICK, 3'd7);
    wait_drained();

    for (pass_i = 0; pass_i < 5; pass_i++) begin
      set_parking(pass_i % 2 == 0);
      case (pass_i)
        1: begin send_idle_pct = 53; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 53; end
        3: begin send_idle_pct = 32; stall_pct = 32; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      if (pass_i == 2) begin
        // Let the pipeline empty completely before the second half.
        add_traffic(65);
        wait_drained();
        add_traffic(65);
      end else begin
        add_traffic(130);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d results for %0d requests: %0d door cycles, %0d full-stack drops,",
             checked_count, sent_count, door_count, drop_count);
    $display("with top and bottom parking under four sender/receiver idle mixes.");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
